>>> rtl/crrb_pkg.sv
`default_nettype none

package crrb_pkg;

   localparam int unsigned LenWidth   = 12;
   localparam int unsigned CountWidth = 12;

   typedef enum logic [2:0] {
      CMD_RESERVE  = 3'd0,
      CMD_PUSH     = 3'd1,
      CMD_COMMIT   = 3'd2,
      CMD_ROLLBACK = 3'd3,
      CMD_PEEK     = 3'd4,
      CMD_RELEASE  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_NO_DATA = 2'd2,
      ST_BAD     = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [LenWidth-1:0]   length;
      logic [LenWidth-1:0]   offset;
      logic [7:0]            data_byte;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [7:0]            read_byte;
      logic [CountWidth-1:0] used_count;
      logic [CountWidth-1:0] idle_count;
   } rsp_type;

   typedef struct packed {
      logic write_en;
      logic read_en;
   } mem_req_type;

endpackage

`default_nettype wire

>>> rtl/crrb_mem.sv
`default_nettype none

module crrb_mem
   import crrb_pkg::*;
#(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  wire logic          clock,
   input  wire mem_req_type   mem_req,
   input  wire logic [AW-1:0] mem_addr,
   input  wire logic [7:0]    mem_wdata,
   output logic [7:0]         mem_rdata
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rdata_ff;

   // single port: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_req.write_en) begin
         store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_req.read_en) begin
         rdata_ff <= store_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

>>> rtl/crrb_ctrl.sv
`default_nettype none

module crrb_ctrl
   import crrb_pkg::*;
#(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire req_type       req,
   output mem_req_type        mem_req,
   output logic [AW-1:0]      mem_addr,
   output logic [7:0]         mem_wdata,
   output logic               rsp_valid,
   output logic               peek_ok,
   output rsp_type            rsp_base
);

   localparam int unsigned XW = ((AW > LenWidth) ? AW : LenWidth) + 2;
   localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
   localparam logic [XW-1:0] ONE_X   = XW'(1);

   logic [AW-1:0]       wp_ff, wp_in;
   logic [AW-1:0]       rp_ff, rp_in;
   logic [AW-1:0]       swp_ff, swp_in;
   logic [LenWidth-1:0] rl_ff, rl_in;
   logic [LenWidth-1:0] fc_ff, fc_in;
   status_type          status_ff, status_in;
   logic                peek_ok_ff, peek_ok_in;
   logic                valid_ff;

   logic [XW-1:0] wp_x, rp_x, swp_x, len_x, off_x, rl_x, fc_x;
   logic [XW-1:0] used_x, idle_x, wtail_x, rtail_x, rstart_x;
   logic          wwrap, room, rwrap, avail_ok;

   function automatic logic [AW-1:0] wrap_addr(input logic [XW-1:0] v);
      logic [XW-1:0] r;
      r = (v >= DEPTH_X) ? v - DEPTH_X : v;
      return r[AW-1:0];
   endfunction

   always_comb begin
      wp_x  = XW'(wp_ff);
      rp_x  = XW'(rp_ff);
      swp_x = XW'(swp_ff);
      len_x = XW'(req.length);
      off_x = XW'(req.offset);
      rl_x  = XW'(rl_ff);
      fc_x  = XW'(fc_ff);

      used_x = (swp_x >= rp_x) ? swp_x - rp_x : DEPTH_X + swp_x - rp_x;
      idle_x = DEPTH_X - used_x - ONE_X;

      // writer skips a short tail only when it is level with or ahead of the reader
      wtail_x = DEPTH_X - swp_x;
      wwrap   = (swp_x >= rp_x) && (wtail_x < len_x);
      room    = wwrap ? (idle_x >= wtail_x + len_x) : (idle_x >= len_x);

      // reader skips a short tail only when the data wrapped around or the ring is empty
      rtail_x  = DEPTH_X - rp_x;
      rwrap    = (rp_x >= swp_x) && (rtail_x < len_x);
      avail_ok = rwrap ? (used_x >= rtail_x + len_x) : (used_x >= len_x);
      rstart_x = rwrap ? '0 : rp_x;
   end

   always_comb begin
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      swp_in     = swp_ff;
      rl_in      = rl_ff;
      fc_in      = fc_ff;
      status_in  = ST_OK;
      peek_ok_in = 1'b0;
      mem_req    = '0;
      mem_addr   = '0;
      mem_wdata  = req.data_byte;

      unique case (req.cmd)
         CMD_RESERVE: begin
            if (rl_ff != '0) begin
               status_in = ST_BAD;
            end else if (req.length != '0) begin
               if (room) begin
                  wp_in = wwrap ? '0 : swp_ff;
                  rl_in = req.length;
                  fc_in = '0;
               end else begin
                  status_in = ST_NO_ROOM;
               end
            end
         end
         CMD_PUSH: begin
            if (rl_ff == '0 || fc_ff >= rl_ff) begin
               status_in = ST_BAD;
            end else begin
               mem_req.write_en = accept;
               mem_addr         = wrap_addr(wp_x + fc_x);
               fc_in            = fc_ff + 1'b1;
            end
         end
         CMD_COMMIT: begin
            if (rl_ff == '0 || fc_ff < rl_ff) begin
               status_in = ST_BAD;
            end else begin
               wp_in  = wrap_addr(wp_x + rl_x);
               swp_in = wrap_addr(wp_x + rl_x);
               rl_in  = '0;
               fc_in  = '0;
            end
         end
         CMD_ROLLBACK: begin
            if (rl_ff == '0) begin
               status_in = ST_BAD;
            end else begin
               wp_in = swp_ff;
               rl_in = '0;
               fc_in = '0;
            end
         end
         CMD_PEEK: begin
            if (off_x >= len_x) begin
               status_in = ST_BAD;
            end else if (!avail_ok) begin
               status_in = ST_NO_DATA;
            end else begin
               mem_req.read_en = accept;
               mem_addr        = wrap_addr(rstart_x + off_x);
               peek_ok_in      = 1'b1;
            end
         end
         CMD_RELEASE: begin
            if (req.length != '0) begin
               if (avail_ok) begin
                  rp_in = wrap_addr(rstart_x + len_x);
               end else begin
                  status_in = ST_NO_DATA;
               end
            end
         end
         default: begin
            status_in = ST_BAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         rp_ff      <= '0;
         swp_ff     <= '0;
         rl_ff      <= '0;
         fc_ff      <= '0;
         valid_ff   <= 1'b0;
         status_ff  <= ST_OK;
         peek_ok_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
         if (accept) begin
            wp_ff      <= wp_in;
            rp_ff      <= rp_in;
            swp_ff     <= swp_in;
            rl_ff      <= rl_in;
            fc_ff      <= fc_in;
            status_ff  <= status_in;
            peek_ok_ff <= peek_ok_in;
         end
      end
   end

   // counts come straight from the pointers, which already hold the item's effect
   assign rsp_valid           = valid_ff;
   assign peek_ok             = peek_ok_ff;
   assign rsp_base.status     = status_ff;
   assign rsp_base.read_byte  = '0;
   assign rsp_base.used_count = used_x[CountWidth-1:0];
   assign rsp_base.idle_count = idle_x[CountWidth-1:0];

`ifndef SYNTHESIS
   a_fill_within_reservation: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= rl_ff)
      else $error("fill cursor ran past the reservation");

   a_no_reservation_pointers: assert property (@(posedge clock) disable iff (reset)
      (rl_ff == '0) |-> (wp_ff == swp_ff))
      else $error("write pointer differs from committed pointer with no reservation");

   a_pointers_in_range: assert property (@(posedge clock) disable iff (reset)
      (XW'(rp_ff) < DEPTH_X) && (XW'(swp_ff) < DEPTH_X) && (XW'(wp_ff) < DEPTH_X))
      else $error("pointer outside the ring");

   a_commit_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req.cmd == CMD_COMMIT && status_in == ST_OK) |=> (rl_ff == '0))
      else $error("reservation still open after a good commit");

   a_single_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.write_en && mem_req.read_en))
      else $error("byte store read and written in one cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/contiguous_record_ring_buffer_top.sv
// latency: a result strobes on rsp_valid the cycle after its item is accepted
// throughput: one item per cycle, busy stays low; peek reads the byte store in
//   the accept cycle and the registered read data is shown with the result
// the receiver cannot stall: each result is shown for exactly one cycle
// synchronous reset empties the ring; the byte store itself is not cleared
`default_nettype none

module contiguous_record_ring_buffer_top
   import crrb_pkg::*;
#(
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic          accept;
   mem_req_type   mem_req;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;
   logic          peek_ok;
   rsp_type       rsp_base;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   crrb_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_item),
      .mem_req   (mem_req),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .rsp_valid (rsp_valid),
      .peek_ok   (peek_ok),
      .rsp_base  (rsp_base)
   );

   crrb_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   always_comb begin
      rsp_item           = rsp_base;
      rsp_item.read_byte = peek_ok ? mem_rdata : 8'd0;
   end

endmodule

`default_nettype wire

>>> verif/tb_contiguous_record_ring_buffer_top.sv
`timescale 1ns / 100ps

module tb_contiguous_record_ring_buffer_top;
   import crrb_pkg::*;

   localparam int RING_DEPTH = 4096;
   localparam int GAP_MAX = 15;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_FIELD = 4095;
   // command codes the block does not define
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   req_type req_item = '0;
   logic busy;
   logic rsp_valid;
   rsp_type rsp_item;

   contiguous_record_ring_buffer_top #(
      .DEPTH (RING_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   // ring state as the block should hold it
   logic [7:0] ring_bytes [RING_DEPTH];
   bit ring_filled [RING_DEPTH];
   int wr_base = 0;
   int rd_ptr = 0;
   int commit_ptr = 0;
   int open_len = 0;
   int fill_cnt = 0;

   rsp_type expected_rsps [$];
   int record_lens [$];
   int abandon_at = -1;
   bit no_idle_run = 1'b0;
   int run_left = 0;

   int items_sent = 0;
   int results_checked = 0;
   int failures = 0;
   int peek_hits = 0;
   int tail_skips = 0;
   int cycle_count = 0;

   function automatic int used_bytes();
      return (commit_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
   endfunction

   // start of the oldest len readable bytes, -1 when there are not enough
   function automatic int readable_start(int len);
      int avail;
      int first;
      int tail;
      avail = used_bytes();
      first = rd_ptr;
      tail = RING_DEPTH - rd_ptr;
      if (rd_ptr >= commit_ptr && tail < len) begin
         avail -= tail;
         first = 0;
      end
      return (avail >= len) ? first : -1;
   endfunction

   function automatic bit peek_is_blank(req_type it);
      int first;
      if (it.cmd != CMD_PEEK || it.offset >= it.length) return 1'b0;
      first = readable_start(int'(it.length));
      if (first < 0) return 1'b0;
      return !ring_filled[(first + int'(it.offset)) % RING_DEPTH];
   endfunction

   function automatic rsp_type apply_command(req_type it);
      rsp_type res;
      int len;
      int off;
      int first;
      int tail;
      int idle;
      int used;
      int addr;
      bit skipped;
      res = '0;
      res.status = ST_OK;
      len = int'(it.length);
      off = int'(it.offset);
      skipped = 1'b0;
      case (it.cmd)
         CMD_RESERVE: begin
            if (open_len != 0) begin
               res.status = ST_BAD;
            end else if (len > 0) begin
               idle = RING_DEPTH - used_bytes() - 1;
               tail = RING_DEPTH - commit_ptr;
               first = commit_ptr;
               // short tail is skipped and counts as used
               if (commit_ptr >= rd_ptr && tail < len) begin
                  idle -= tail;
                  first = 0;
                  skipped = 1'b1;
               end
               if (idle >= len) begin
                  wr_base = first;
                  open_len = len;
                  fill_cnt = 0;
                  if (skipped) tail_skips++;
               end else begin
                  res.status = ST_NO_ROOM;
               end
            end
         end
         CMD_PUSH: begin
            if (open_len == 0 || fill_cnt >= open_len) begin
               res.status = ST_BAD;
            end else begin
               addr = (wr_base + fill_cnt) % RING_DEPTH;
               ring_bytes[addr] = it.data_byte;
               ring_filled[addr] = 1'b1;
               fill_cnt++;
            end
         end
         CMD_COMMIT: begin
            if (open_len == 0 || fill_cnt < open_len) begin
               res.status = ST_BAD;
            end else begin
               wr_base = (wr_base + open_len) % RING_DEPTH;
               commit_ptr = wr_base;
               open_len = 0;
               fill_cnt = 0;
            end
         end
         CMD_ROLLBACK: begin
            if (open_len == 0) begin
               res.status = ST_BAD;
            end else begin
               wr_base = commit_ptr;
               open_len = 0;
               fill_cnt = 0;
            end
         end
         CMD_PEEK: begin
            if (off >= len) begin
               res.status = ST_BAD;
            end else begin
               first = readable_start(len);
               if (first < 0) begin
                  res.status = ST_NO_DATA;
               end else begin
                  res.read_byte = ring_bytes[(first + off) % RING_DEPTH];
                  peek_hits++;
               end
            end
         end
         CMD_RELEASE: begin
            if (len > 0) begin
               first = readable_start(len);
               if (first < 0) res.status = ST_NO_DATA;
               else rd_ptr = (first + len) % RING_DEPTH;
            end
         end
         default: res.status = ST_BAD;
      endcase
      used = used_bytes();
      res.used_count = CountWidth'(used);
      res.idle_count = CountWidth'(RING_DEPTH - used - 1);
      return res;
   endfunction

   task automatic send_command(req_type it);
      int gap;
      int commit_len;
      rsp_type res;
      if (run_left <= 0) begin
         no_idle_run = ($urandom_range(0, 3) == 0);
         run_left = $urandom_range(8, 40);
      end
      run_left--;
      gap = no_idle_run ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      commit_len = open_len;
      res = apply_command(it);
      expected_rsps.push_back(res);
      items_sent++;
      // keep the list of published records in step with the ring
      if (it.cmd == CMD_COMMIT && res.status == ST_OK) record_lens.push_back(commit_len);
      if (it.cmd == CMD_RELEASE && res.status == ST_OK && it.length != 0) begin
         if (record_lens.size() != 0 && record_lens[0] == int'(it.length))
            void'(record_lens.pop_front());
         else
            record_lens.delete();
      end
   endtask

   task automatic issue(cmd_type cmd, int len = 0, int off = 0, int data = 0);
      req_type it;
      it.cmd = cmd;
      it.length = LenWidth'(len);
      it.offset = LenWidth'(off);
      it.data_byte = 8'(data);
      send_command(it);
   endtask

   task automatic write_record(int len);
      issue(CMD_RESERVE, len);
      repeat (len) issue(CMD_PUSH, 0, 0, $urandom_range(0, 255));
      issue(CMD_COMMIT);
   endtask

   // writer and reader working on whole records, with some stray commands mixed in
   task automatic run_traffic(int item_goal, bit long_records, int noise_pct);
      req_type it;
      int goal_base;
      int len;
      int pick;
      goal_base = items_sent;
      while (items_sent - goal_base < item_goal) begin
         it.cmd = CMD_PUSH;
         it.length = '0;
         it.offset = '0;
         it.data_byte = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < noise_pct) begin
            it.cmd = cmd_type'($urandom_range(0, 7));
            it.length = LenWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_FIELD)
                                                             : $urandom_range(0, 15));
            it.offset = LenWidth'(($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_FIELD)
                                                             : $urandom_range(0, 15));
            // a stray release must not move the reader off a record boundary
            if (it.cmd == CMD_RELEASE)
               it.length = LenWidth'((used_bytes() < MAX_FIELD && $urandom_range(0, 1))
                  ? $urandom_range(used_bytes() + 1, MAX_FIELD) : 0);
            if (it.cmd == CMD_RESERVE) abandon_at = $urandom_range(0, 20);
         end else if (open_len != 0) begin
            if (fill_cnt == abandon_at) it.cmd = CMD_ROLLBACK;
            else if (fill_cnt < open_len) it.cmd = CMD_PUSH;
            else it.cmd = CMD_COMMIT;
         end else if (record_lens.size() == 0 || $urandom_range(0, 1)) begin
            pick = $urandom_range(0, 99);
            if (long_records)
               len = (pick < 95) ? $urandom_range(100, 900) : $urandom_range(901, 2000);
            else if (pick < 80)
               len = $urandom_range(1, 12);
            else if (pick < 97)
               len = $urandom_range(13, 200);
            else
               len = $urandom_range(201, 1200);
            it.cmd = CMD_RESERVE;
            it.length = LenWidth'(len);
            abandon_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
         end else begin
            len = record_lens[0];
            it.length = LenWidth'(len);
            if ($urandom_range(0, 2) == 0) begin
               it.cmd = CMD_RELEASE;
            end else begin
               it.cmd = CMD_PEEK;
               case ($urandom_range(0, 3))
                  0: it.offset = '0;
                  1: it.offset = LenWidth'(len - 1);
                  default: it.offset = LenWidth'($urandom_range(0, len - 1));
               endcase
            end
         end
         // never read a byte that was skipped over and never written
         if (peek_is_blank(it)) it.offset = it.length;
         send_command(it);
      end
   endtask

   // from an empty ring with the reader at zero: one byte more than fits, then exactly
   // what fits, so the guard byte is the only one kept free
   task automatic test_room_limit();
      int idle;
      write_record(5);
      idle = RING_DEPTH - used_bytes() - 1;
      issue(CMD_RESERVE, idle + 1);
      issue(CMD_RESERVE, idle);
      issue(CMD_PUSH, 0, 0, $urandom_range(0, 255));
      issue(CMD_ROLLBACK);
      issue(CMD_PEEK, 5, 4);
      issue(CMD_RELEASE, 5);
   endtask

   task automatic test_special_cases();
      issue(CMD_RESERVE, 0);
      issue(CMD_PUSH, 0, 0, 8'hFF);
      issue(CMD_COMMIT);
      issue(CMD_ROLLBACK);
      issue(CMD_PEEK, 0, 0);
      issue(CMD_PEEK, MAX_FIELD, MAX_FIELD);
      issue(CMD_PEEK, 4, 0);
      issue(CMD_RELEASE, 0);
      issue(CMD_RELEASE, MAX_FIELD);
      issue(cmd_type'(CMD_SPARE_A), MAX_FIELD, MAX_FIELD, 8'hFF);
      issue(cmd_type'(CMD_SPARE_B), MAX_FIELD, MAX_FIELD, 8'hFF);
      issue(CMD_RESERVE, 3);
      issue(CMD_RESERVE, 2);
      issue(CMD_PUSH, 0, 0, 8'h00);
      issue(CMD_COMMIT);
      issue(CMD_PUSH, 0, 0, 8'h5A);
      issue(CMD_PUSH, 0, 0, 8'hFF);
      issue(CMD_PUSH, 0, 0, 8'hA5);
      issue(CMD_COMMIT);
      issue(CMD_RESERVE, MAX_FIELD);
      issue(CMD_RESERVE, 4);
      issue(CMD_PUSH, 0, 0, 8'h3C);
      issue(CMD_ROLLBACK);
      issue(CMD_PEEK, 3, 2);
      issue(CMD_PEEK, 4, 0);
      issue(CMD_RELEASE, 3);
   endtask

   task automatic test_mixed_records();
      run_traffic(560, 1'b0, 8);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result with nothing outstanding: %p", rsp_item);
            failures++;
         end else begin
            want = expected_rsps.pop_front();
            results_checked++;
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               failures++;
            end
            if (rsp_item.read_byte !== want.read_byte) begin
               $error("read_byte: expected %0d, got %0d", want.read_byte, rsp_item.read_byte);
               failures++;
            end
            if (rsp_item.used_count !== want.used_count) begin
               $error("used_count: expected %0d, got %0d", want.used_count,
                      rsp_item.used_count);
               failures++;
            end
            if (rsp_item.idle_count !== want.idle_count) begin
               $error("idle_count: expected %0d, got %0d", want.idle_count,
                      rsp_item.idle_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[contiguous_record_ring_buffer_top] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_room_limit();
      test_special_cases();
      test_mixed_records();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         failures++;
      end
      $display("sent %0d items and checked %0d results; %0d peeks returned data,",
               items_sent, results_checked, peek_hits);
      $display("%0d reservations skipped a short tail to the ring start", tail_skips);
      if (failures == 0) begin
         $display("[contiguous_record_ring_buffer_top] OK");
      end else begin
         $display("[contiguous_record_ring_buffer_top] ERROR");
      end
      $finish;
   end

endmodule
